/* hdl/isc_pkg.sv */
// isc_pkg: shared types and codes for the integer stack calculator
// no dependencies; used by the top level and the multiply/divide unit

package isc_pkg;

    localparam int CMD_W    = 4;
    localparam int OPND_W   = 32;
    localparam int TOP_W    = 32;
    localparam int DEPTH_W  = 7;
    localparam int STATUS_W = 2;

    // opcodes
    localparam logic [CMD_W-1:0] CMD_CONST = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SUB   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_MUL   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_DIV   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_MAX   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_MIN   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_NEG   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_DUP   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_SWAP  = 4'd9;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [OPND_W-1:0] operand;
    } t_in_item;

    typedef struct packed {
        logic signed [TOP_W-1:0] top_value;
        logic [DEPTH_W-1:0]      depth;
        logic [STATUS_W-1:0]     status;
    } t_out_item;

    // request to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_ctrl;

endpackage

/* hdl/isc_stack_mem.sv */
// isc_stack_mem: stack entry storage, one write port and two registered read ports
// no dependencies

module isc_stack_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* hdl/isc_muldiv.sv */
// isc_muldiv: iterative multiply (shift-add) and signed divide (restoring), one bit a cycle
// depends on isc_pkg for the request struct

module isc_muldiv #(
    parameter int WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  isc_pkg::t_md_ctrl   i_ctrl,
    input  logic [WIDTH-1:0]    i_a,
    input  logic [WIDTH-1:0]    i_b,
    output logic                o_done,
    output logic [WIDTH-1:0]    o_result
);

    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_FIN
    } t_md_state;

    t_md_state        r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_acc;   // product accumulator or partial remainder
    logic [WIDTH-1:0] r_x;     // multiplicand or dividend/quotient
    logic [WIDTH-1:0] r_y;     // multiplier or divisor magnitude
    logic             r_is_div;
    logic             r_neg;
    logic             r_done;
    logic [WIDTH-1:0] r_result;

    logic [WIDTH-1:0] mag_a;
    logic [WIDTH-1:0] mag_b;
    logic [WIDTH:0]   rem_shift;
    logic [WIDTH:0]   rem_diff;
    logic             rem_ge;

    assign mag_a = i_a[WIDTH-1] ? WIDTH'(-i_a) : i_a;
    assign mag_b = i_b[WIDTH-1] ? WIDTH'(-i_b) : i_b;

    assign rem_shift = {r_acc, r_x[WIDTH-1]};
    assign rem_ge    = (rem_shift >= {1'b0, r_y});
    assign rem_diff  = rem_shift - {1'b0, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            // done pulses for one cycle, right after the finishing step
            r_done <= (r_state == MD_FIN);
            case (r_state)
                MD_IDLE: begin
                    if (i_ctrl.start) begin
                        r_is_div <= i_ctrl.is_div;
                        r_neg    <= i_a[WIDTH-1] ^ i_b[WIDTH-1];
                        r_acc    <= '0;
                        r_cnt    <= CNT_W'(WIDTH - 1);
                        if (i_ctrl.is_div) begin
                            r_x <= mag_a;
                            r_y <= mag_b;
                        end else begin
                            r_x <= i_a;
                            r_y <= i_b;
                        end
                        r_state <= MD_RUN;
                    end
                end
                MD_RUN: begin
                    if (r_is_div) begin
                        r_acc <= rem_ge ? rem_diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
                        r_x   <= {r_x[WIDTH-2:0], rem_ge};
                    end else begin
                        if (r_y[0]) begin
                            r_acc <= r_acc + r_x;
                        end
                        r_x <= {r_x[WIDTH-2:0], 1'b0};
                        r_y <= {1'b0, r_y[WIDTH-1:1]};
                    end
                    if (r_cnt == '0) begin
                        r_state <= MD_FIN;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                MD_FIN: begin
                    // quotient sign fixup; most negative / -1 wraps on its own
                    if (r_is_div) begin
                        r_result <= r_neg ? WIDTH'(-r_x) : r_x;
                    end else begin
                        r_result <= r_acc;
                    end
                    r_state <= MD_IDLE;
                end
                default: begin
                    r_state <= MD_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* hdl/integer_stack_calculator.sv */
// integer_stack_calculator: top level, command sequencer over the stack memory
// depends on isc_pkg, isc_stack_mem and isc_muldiv

// One command is handled at a time. After a transfer on the input channel the
// block reads the two top entries from the stack memory (registered reads),
// works out the result and writes it back; const, add, sub, max, min, neg
// and dup pass through S_READ, S_EXEC, S_WRITE and S_DONE, and swap adds
// S_SWAP (two writes through the single write port). mul and div go through
// the shared bit-serial multiply/divide unit, waiting in S_ARITH for its
// result. The input stays stalled from its transfer until the result has
// moved into the output register; a result waiting there holds up the next
// command only in S_DONE. Errors (underflow, overflow, divide by zero) leave
// the stack untouched. The stack memory needs no clearing after reset:
// entries at or above the current depth are never used.

module integer_stack_calculator #(
    parameter int STACK_DEPTH = 64,
    parameter int WORD_WIDTH  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  isc_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output isc_pkg::t_out_item  o_out
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_ARITH,
        S_WRITE,
        S_SWAP,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   r_count_nx;
    logic [isc_pkg::CMD_W-1:0]       r_cmd;
    logic [WORD_WIDTH-1:0]           r_opnd;
    logic [WORD_WIDTH-1:0]           r_a;
    logic [WORD_WIDTH-1:0]           r_top;
    logic [WORD_WIDTH-1:0]           r_wdata;
    logic [AW-1:0]                   r_wr_addr;
    logic                            r_wr_en;
    logic                            r_swap;
    logic [isc_pkg::STATUS_W-1:0]    r_status;
    logic                            r_out_valid;
    isc_pkg::t_out_item              r_out;

    logic [WORD_WIDTH-1:0]           rd_a;
    logic [WORD_WIDTH-1:0]           rd_b;
    logic                            mem_we;
    logic [AW-1:0]                   raddr_a;
    logic [AW-1:0]                   raddr_b;

    isc_pkg::t_md_ctrl               md_ctrl;
    logic                            md_done;
    logic [WORD_WIDTH-1:0]           md_result;

    // execute-stage decisions
    logic [isc_pkg::STATUS_W-1:0]    ex_status;
    logic [WORD_WIDTH-1:0]           ex_top;
    logic                            ex_we;
    logic [AW-1:0]                   ex_waddr;
    logic [WORD_WIDTH-1:0]           ex_wdata;
    logic [CW-1:0]                   ex_count;
    logic                            ex_use_md;
    logic                            ex_swap;
    logic                            has1;
    logic                            has2;
    logic                            full;

    assign raddr_a = AW'(r_count - CW'(1));
    assign raddr_b = AW'(r_count - CW'(2));
    assign mem_we  = r_wr_en && (r_state == S_WRITE || r_state == S_SWAP);

    isc_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (WORD_WIDTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (r_wr_addr),
        .i_wdata   (r_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign md_ctrl.start  = (r_state == S_EXEC) && ex_use_md;
    assign md_ctrl.is_div = (r_cmd == isc_pkg::CMD_DIV);

    isc_muldiv #(
        .WIDTH (WORD_WIDTH)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (md_ctrl),
        .i_a      (rd_a),
        .i_b      (rd_b),
        .o_done   (md_done),
        .o_result (md_result)
    );

    assign has1 = (r_count != '0);
    assign has2 = (r_count >= CW'(2));
    assign full = (r_count >= CW'(STACK_DEPTH));

    always_comb begin
        ex_status = isc_pkg::ST_OK;
        ex_top    = has1 ? rd_a : '0;
        ex_we     = 1'b0;
        ex_waddr  = AW'(r_count);
        ex_wdata  = r_opnd;
        ex_count  = r_count;
        ex_use_md = 1'b0;
        ex_swap   = 1'b0;
        case (r_cmd)
            isc_pkg::CMD_CONST: begin
                if (full) begin
                    ex_status = isc_pkg::ST_OVER;
                end else begin
                    ex_we    = 1'b1;
                    ex_wdata = r_opnd;
                    ex_top   = r_opnd;
                    ex_count = r_count + CW'(1);
                end
            end
            isc_pkg::CMD_DUP: begin
                if (!has1) begin
                    ex_status = isc_pkg::ST_UNDER;
                end else if (full) begin
                    ex_status = isc_pkg::ST_OVER;
                end else begin
                    ex_we    = 1'b1;
                    ex_wdata = rd_a;
                    ex_top   = rd_a;
                    ex_count = r_count + CW'(1);
                end
            end
            isc_pkg::CMD_ADD, isc_pkg::CMD_SUB, isc_pkg::CMD_MUL,
            isc_pkg::CMD_DIV, isc_pkg::CMD_MAX, isc_pkg::CMD_MIN: begin
                if (!has2) begin
                    ex_status = isc_pkg::ST_UNDER;
                end else if (r_cmd == isc_pkg::CMD_DIV && rd_b == '0) begin
                    ex_status = isc_pkg::ST_DIVZ;
                end else begin
                    ex_we    = 1'b1;
                    ex_waddr = AW'(r_count - CW'(2));
                    ex_count = r_count - CW'(1);
                    case (r_cmd)
                        isc_pkg::CMD_ADD: ex_wdata = rd_a + rd_b;
                        isc_pkg::CMD_SUB: ex_wdata = rd_a - rd_b;
                        isc_pkg::CMD_MAX: begin
                            ex_wdata = ($signed(rd_a) < $signed(rd_b)) ? rd_b : rd_a;
                        end
                        isc_pkg::CMD_MIN: begin
                            ex_wdata = ($signed(rd_b) < $signed(rd_a)) ? rd_b : rd_a;
                        end
                        default: ex_use_md = 1'b1;
                    endcase
                    ex_top = ex_wdata;
                end
            end
            isc_pkg::CMD_NEG: begin
                if (!has1) begin
                    ex_status = isc_pkg::ST_UNDER;
                end else begin
                    ex_we    = 1'b1;
                    ex_waddr = AW'(r_count - CW'(1));
                    ex_wdata = WORD_WIDTH'(-rd_a);
                    ex_top   = ex_wdata;
                end
            end
            isc_pkg::CMD_SWAP: begin
                if (!has2) begin
                    ex_status = isc_pkg::ST_UNDER;
                end else begin
                    // top slot gets b first, the slot below gets a next cycle
                    ex_we    = 1'b1;
                    ex_waddr = AW'(r_count - CW'(1));
                    ex_wdata = rd_b;
                    ex_top   = rd_b;
                    ex_swap  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wr_en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // in S_DONE the output register is reloaded below instead
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_in.cmd;
                        r_opnd  <= WORD_WIDTH'($signed(i_in.operand));
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // memory read of the two top entries lands this cycle
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_a        <= rd_a;
                    r_status   <= ex_status;
                    r_top      <= ex_top;
                    r_wr_en    <= ex_we;
                    r_wr_addr  <= ex_waddr;
                    r_wdata    <= ex_wdata;
                    r_count_nx <= ex_count;
                    r_swap     <= ex_swap;
                    r_state    <= ex_use_md ? S_ARITH : S_WRITE;
                end
                S_ARITH: begin
                    if (md_done) begin
                        r_wdata <= md_result;
                        r_top   <= md_result;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_count <= r_count_nx;
                    if (r_swap) begin
                        r_wr_addr <= r_wr_addr - 1'b1;
                        r_wdata   <= r_a;
                        r_state   <= S_SWAP;
                    end else begin
                        r_wr_en <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_SWAP: begin
                    r_wr_en <= 1'b0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid     <= 1'b1;
                        r_out.top_value <= isc_pkg::TOP_W'($signed(r_top));
                        r_out.depth     <= isc_pkg::DEPTH_W'(r_count);
                        r_out.status    <= r_status;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* test/tb_integer_stack_calculator.sv */
// tb_integer_stack_calculator: self-checking bench for the stack calculator
// drives commands with random gaps and stalls, predicts each result in-bench
// depends on isc_pkg and integer_stack_calculator
`timescale 1ns / 1ps

module tb_integer_stack_calculator;

    localparam int STACK_DEPTH       = 64;
    localparam int RANDOM_ITEMS      = 1680;
    localparam int LONG_HOLD_ITEM    = 600;
    localparam int DRAIN_PAUSE_ITEM  = 1200;
    localparam int LONG_HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES     = 60;
    localparam int CYCLE_LIMIT       = 1000000;
    localparam int MAX_GAP           = 18;
    localparam int DIRECTED_ROWS     = 29;

    localparam logic [isc_pkg::CMD_W-1:0] CMD_FIRST_UNUSED = 4'd10;
    localparam logic [isc_pkg::CMD_W-1:0] CMD_LAST_UNUSED  = 4'd15;

    localparam logic signed [isc_pkg::OPND_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [isc_pkg::OPND_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [isc_pkg::CMD_W-1:0]  cmd;
        logic [isc_pkg::OPND_W-1:0] operand;
        logic [7:0]                 repeats;
        logic                       has_literal;
        isc_pkg::t_out_item         literal;
    } t_directed_row;

    // hand-written expectations only where the value is obvious
    localparam t_directed_row DIRECTED_TABLE [0:DIRECTED_ROWS-1] = '{
        '{isc_pkg::CMD_ADD,   32'd0,    8'd1, 1'b1, '{32'sd0, 7'd0, isc_pkg::ST_UNDER}},
        '{isc_pkg::CMD_NEG,   32'd0,    8'd1, 1'b1, '{32'sd0, 7'd0, isc_pkg::ST_UNDER}},
        '{isc_pkg::CMD_DUP,   32'd0,    8'd1, 1'b1, '{32'sd0, 7'd0, isc_pkg::ST_UNDER}},
        '{isc_pkg::CMD_SWAP,  32'd0,    8'd1, 1'b1, '{32'sd0, 7'd0, isc_pkg::ST_UNDER}},
        '{CMD_LAST_UNUSED,    32'd0,    8'd1, 1'b1, '{32'sd0, 7'd0, isc_pkg::ST_OK}},
        '{isc_pkg::CMD_CONST, WORD_MAX, 8'd1, 1'b1, '{WORD_MAX, 7'd1, isc_pkg::ST_OK}},
        '{isc_pkg::CMD_SUB,   32'd0,    8'd1, 1'b1, '{WORD_MAX, 7'd1, isc_pkg::ST_UNDER}},
        '{isc_pkg::CMD_CONST, WORD_MIN, 8'd1, 1'b1, '{WORD_MIN, 7'd2, isc_pkg::ST_OK}},
        '{isc_pkg::CMD_ADD,   32'd0,    8'd1, 1'b1, '{-32'sd1, 7'd1, isc_pkg::ST_OK}},
        '{isc_pkg::CMD_NEG,   32'd0,    8'd1, 1'b0, '0},
        '{isc_pkg::CMD_CONST, 32'd0,    8'd1, 1'b0, '0},
        '{isc_pkg::CMD_SWAP,  32'd0,    8'd1, 1'b0, '0},
        '{isc_pkg::CMD_DIV,   32'd0,    8'd1, 1'b1, '{32'sd1, 7'd2, isc_pkg::ST_DIVZ}},
        '{isc_pkg::CMD_MUL,   32'd0,    8'd1, 1'b0, '0},
        '{isc_pkg::CMD_CONST, 32'hffff_ffff, 8'd1, 1'b0, '0},
        '{isc_pkg::CMD_CONST, WORD_MIN, 8'd1, 1'b0, '0},
        '{isc_pkg::CMD_DIV,   32'd0,    8'd1, 1'b1, '{WORD_MIN, 7'd2, isc_pkg::ST_OK}},
        '{isc_pkg::CMD_CONST, 32'd7,    8'd1, 1'b0, '0},
        '{isc_pkg::CMD_MAX,   32'd0,    8'd1, 1'b0, '0},
        '{isc_pkg::CMD_CONST, 32'hffff_fffd, 8'd1, 1'b0, '0},
        '{isc_pkg::CMD_MIN,   32'd0,    8'd1, 1'b0, '0},
        '{isc_pkg::CMD_CONST, WORD_MAX, 8'd1, 1'b0, '0},
        '{isc_pkg::CMD_MUL,   32'd0,    8'd1, 1'b0, '0},
        '{isc_pkg::CMD_DUP,   32'd0,    8'd70, 1'b0, '0},
        '{isc_pkg::CMD_CONST, 32'h5a5a_5a5a, 8'd1, 1'b0, '0},
        '{CMD_FIRST_UNUSED,   32'd0,    8'd1, 1'b0, '0},
        '{isc_pkg::CMD_SUB,   32'd0,    8'd70, 1'b0, '0},
        '{isc_pkg::CMD_NEG,   32'd0,    8'd1, 1'b0, '0},
        '{isc_pkg::CMD_SWAP,  32'd0,    8'd1, 1'b0, '0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    isc_pkg::t_in_item  i_in;
    logic               o_out_valid;
    logic               i_out_stall;
    isc_pkg::t_out_item o_out;

    integer_stack_calculator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // predicted stack contents
    logic signed [isc_pkg::OPND_W-1:0] calc_stack [0:STACK_DEPTH-1];
    int                                calc_depth;

    isc_pkg::t_out_item expected_results [$];
    isc_pkg::t_out_item want_result;
    int                 error_count;
    int                 results_checked;
    int                 commands_sent;
    int                 status_seen [0:3];
    int                 cycle_count;
    bit                 in_quiet;
    bit                 out_quiet;
    bit                 long_hold_req;

    function automatic isc_pkg::t_out_item calc_apply(isc_pkg::t_in_item cmd_item);
        logic signed [isc_pkg::OPND_W-1:0] a;
        logic signed [isc_pkg::OPND_W-1:0] b;
        logic signed [isc_pkg::OPND_W-1:0] r;
        logic signed [63:0]                quotient;
        int                                n;
        isc_pkg::t_out_item                res;
        n = calc_depth;
        a = (n > 0) ? calc_stack[n-1] : '0;
        b = (n > 1) ? calc_stack[n-2] : '0;
        res = '0;
        res.status = isc_pkg::ST_OK;
        case (cmd_item.cmd)
            isc_pkg::CMD_CONST, isc_pkg::CMD_DUP: begin
                if (cmd_item.cmd == isc_pkg::CMD_DUP && n < 1) begin
                    res.status = isc_pkg::ST_UNDER;
                end else if (n >= STACK_DEPTH) begin
                    res.status = isc_pkg::ST_OVER;
                end else begin
                    calc_stack[n] = (cmd_item.cmd == isc_pkg::CMD_CONST) ?
                                    cmd_item.operand : a;
                    calc_depth = n + 1;
                end
            end
            isc_pkg::CMD_ADD, isc_pkg::CMD_SUB, isc_pkg::CMD_MUL,
            isc_pkg::CMD_DIV, isc_pkg::CMD_MAX, isc_pkg::CMD_MIN: begin
                if (n < 2) begin
                    res.status = isc_pkg::ST_UNDER;
                end else if (cmd_item.cmd == isc_pkg::CMD_DIV && b == 0) begin
                    res.status = isc_pkg::ST_DIVZ;
                end else begin
                    // top of stack is the left operand
                    case (cmd_item.cmd)
                        isc_pkg::CMD_ADD: r = a + b;
                        isc_pkg::CMD_SUB: r = a - b;
                        isc_pkg::CMD_MUL: r = a * b;
                        isc_pkg::CMD_DIV: begin
                            // 64-bit divide so min / -1 wraps back to min
                            quotient = 64'(a) / 64'(b);
                            r = quotient[isc_pkg::OPND_W-1:0];
                        end
                        isc_pkg::CMD_MAX: r = (a < b) ? b : a;
                        default: r = (b < a) ? b : a;
                    endcase
                    calc_stack[n-2] = r;
                    calc_depth = n - 1;
                end
            end
            isc_pkg::CMD_NEG: begin
                if (n < 1) res.status = isc_pkg::ST_UNDER;
                else calc_stack[n-1] = -a;
            end
            isc_pkg::CMD_SWAP: begin
                if (n < 2) begin
                    res.status = isc_pkg::ST_UNDER;
                end else begin
                    calc_stack[n-1] = b;
                    calc_stack[n-2] = a;
                end
            end
            default: ;
        endcase
        res.top_value = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
        res.depth = calc_depth[isc_pkg::DEPTH_W-1:0];
        return res;
    endfunction

    // offer one command, wait for its transfer, record what should come back
    task automatic send_command(input isc_pkg::t_in_item cmd_item, input bit has_literal,
                                input isc_pkg::t_out_item literal_result,
                                input bit drain_first);
        int                 gap;
        isc_pkg::t_out_item predicted;
        gap = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0 || drain_first) begin
            i_in_valid <= 1'b0;
            if (drain_first) begin
                do @(posedge i_clk); while (expected_results.size() != 0);
            end
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= cmd_item;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predicted = calc_apply(cmd_item);
        status_seen[predicted.status]++;
        expected_results.push_back(has_literal ? literal_result : predicted);
        commands_sent++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("tb_integer_stack_calculator: errors");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: top_value %0d depth %0d status %0d",
                       o_out.top_value, o_out.depth, o_out.status);
                error_count++;
            end else begin
                want_result = expected_results.pop_front();
                results_checked++;
                if (o_out.top_value !== want_result.top_value) begin
                    $error("top_value: expected %0d, got %0d",
                           want_result.top_value, o_out.top_value);
                    error_count++;
                end
                if (o_out.depth !== want_result.depth) begin
                    $error("depth: expected %0d, got %0d", want_result.depth, o_out.depth);
                    error_count++;
                end
                if (o_out.status !== want_result.status) begin
                    $error("status: expected %0d, got %0d", want_result.status, o_out.status);
                    error_count++;
                end
            end
        end
    end

    // result side: random stall after each transfer, plus one long hold
    initial begin
        int wait_cycles;
        int taken;
        taken = 0;
        out_quiet = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (i_rst_n && o_out_valid && !i_out_stall) begin
                taken++;
                if (taken % 40 == 0) out_quiet = ($urandom_range(0, 2) == 0);
                wait_cycles = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
                if (wait_cycles > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    initial begin
        isc_pkg::t_in_item item;
        int                push_bias;
        int                roll;
        int                spare_cmd;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        i_out_stall   = 1'b0;
        error_count   = 0;
        results_checked = 0;
        commands_sent = 0;
        cycle_count   = 0;
        in_quiet      = 1'b0;
        long_hold_req = 1'b0;
        calc_depth    = 0;
        push_bias     = 50;
        for (int s = 0; s < 4; s++) status_seen[s] = 0;
        for (int e = 0; e < STACK_DEPTH; e++) calc_stack[e] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_TABLE[row]) begin
            for (int rep = 0; rep < DIRECTED_TABLE[row].repeats; rep++) begin
                item.cmd     = DIRECTED_TABLE[row].cmd;
                item.operand = DIRECTED_TABLE[row].operand;
                send_command(item, DIRECTED_TABLE[row].has_literal,
                             DIRECTED_TABLE[row].literal, 1'b0);
            end
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // phases that favor pushes or pops walk the depth from empty to full
            if (k % 100 == 0) begin
                case ($urandom_range(0, 3))
                    0:       push_bias = 80;
                    1:       push_bias = 20;
                    default: push_bias = 50;
                endcase
            end
            if (k % 50 == 0) in_quiet = ($urandom_range(0, 2) == 0);
            if (k == LONG_HOLD_ITEM) long_hold_req = 1'b1;

            case ($urandom_range(0, 11))
                0:       item.operand = '0;
                1:       item.operand = -32'sd1;
                2:       item.operand = WORD_MIN;
                3:       item.operand = WORD_MAX;
                4:       item.operand = 32'sd1;
                5, 6: begin
                    item.operand = $urandom_range(0, 40);
                    item.operand = item.operand - 32'sd20;
                end
                default: item.operand = $urandom;
            endcase

            roll = $urandom_range(0, 99);
            if (roll < push_bias) begin
                item.cmd = ($urandom_range(0, 4) == 0) ? isc_pkg::CMD_DUP : isc_pkg::CMD_CONST;
            end else begin
                case ($urandom_range(0, 15))
                    0, 1:    item.cmd = isc_pkg::CMD_ADD;
                    2, 3:    item.cmd = isc_pkg::CMD_SUB;
                    4, 5:    item.cmd = isc_pkg::CMD_MUL;
                    6, 7, 8: item.cmd = isc_pkg::CMD_DIV;
                    9:       item.cmd = isc_pkg::CMD_MAX;
                    10:      item.cmd = isc_pkg::CMD_MIN;
                    11, 12:  item.cmd = isc_pkg::CMD_NEG;
                    13, 14:  item.cmd = isc_pkg::CMD_SWAP;
                    default: begin
                        spare_cmd = $urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED);
                        item.cmd  = spare_cmd[isc_pkg::CMD_W-1:0];
                    end
                endcase
            end
            send_command(item, 1'b0, '0, k == DRAIN_PAUSE_ITEM);
        end
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d commands sent, %0d results checked", commands_sent, results_checked);
        $display("ok %0d, underflow %0d, overflow %0d, divide by zero %0d",
                 status_seen[isc_pkg::ST_OK], status_seen[isc_pkg::ST_UNDER],
                 status_seen[isc_pkg::ST_OVER], status_seen[isc_pkg::ST_DIVZ]);
        if (error_count == 0) begin
            $display("tb_integer_stack_calculator: clean");
        end else begin
            $display("tb_integer_stack_calculator: errors");
        end
        $finish;
    end

endmodule
